// File: rtl/stm_pkg.sv
// Shared types and constants of the sliding-window template matcher.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none

package stm_pkg;

    // Field widths fixed by the stream and register formats
    localparam int TAP_IDX_W  = 4;
    localparam int POS_W      = 16;
    localparam int COUNT_W    = 17;
    localparam int SCORE_W    = 13;
    localparam int LEN_W      = 5;
    localparam int THR_W      = 17;
    localparam int CFG_ADDR_W = 1;
    localparam int OUT_DATA_W = 32;

    // Arithmetic constants, Q8.8
    localparam int ONE_Q88    = 256;
    localparam int LEN_RESET  = 16;
    localparam int SCORE_MAX  = 8191;
    localparam int POS_MAX    = 65535;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Request kind carried on tuser
    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_DATA = 1'b1
    } func_t;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PATTERN_LENGTH = 1'b0,
        REG_THRESHOLD      = 1'b1
    } cfg_reg_t;

    // Side information that travels with each sample through the sum tree
    typedef struct packed {
        logic             last;
        logic             scored;
        logic [POS_W-1:0] start;
    } meta_t;

endpackage

`default_nettype wire

// File: rtl/stm_cell.sv
// One tap cell: holds one window sample and scores the sample entering it against its pattern word.
// Depends on stm_pkg.
`default_nettype none

module stm_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         shift_en,
    input  wire logic                         clear,
    input  wire logic                         use_tap,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    input  wire logic signed [SAMPLE_BITS-1:0] pattern,
    output logic signed [SAMPLE_BITS-1:0]      window,
    output logic signed [SAMPLE_BITS+1:0]      term
);
    import stm_pkg::*;

    localparam int DW = SAMPLE_BITS + 1;
    localparam int TW = SAMPLE_BITS + 2;

    logic signed [SAMPLE_BITS-1:0] win_reg;
    logic signed [DW-1:0]          diff;
    logic [SAMPLE_BITS-1:0]        mag;

    // Score the sample that enters this cell on the current request
    always_comb
    begin
        diff = DW'(sample_in) - DW'(pattern);
        mag  = diff[DW-1] ? SAMPLE_BITS'(-diff) : SAMPLE_BITS'(diff);
        term = use_tap ? (TW'(ONE_Q88) - $signed({2'b00, mag})) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (clear)
        begin
            win_reg <= '0;
        end
        else if (shift_en)
        begin
            win_reg <= sample_in;
        end
    end

    assign window = win_reg;

endmodule

`default_nettype wire

// File: rtl/stm_tree.sv
// Registered adder tree that reduces the cell scores to one window sum.
// Depends on stm_pkg.
`default_nettype none

module stm_tree #(
    parameter int MAX_TAPS = 16,
    parameter int TERM_W   = 18,
    parameter int SUM_W    = 23
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire stm_pkg::meta_t               in_meta,
    input  wire logic [MAX_TAPS*TERM_W-1:0]   terms,
    output logic                              out_valid,
    output stm_pkg::meta_t                    out_meta,
    output logic signed [SUM_W-1:0]           sum
);
    import stm_pkg::*;

    localparam int LVL = $clog2(MAX_TAPS);
    localparam int POW = 1 << LVL;

    logic signed [SUM_W-1:0] leaf [0:POW-1];
    logic signed [SUM_W-1:0] node_reg [0:LVL][0:POW-1];
    logic [LVL:0]            vld_reg;
    meta_t                   meta_reg [0:LVL];

    // Pad to a power of two with zero leaves
    for (genvar gi = 0; gi < POW; gi++)
    begin : g_leaf
        if (gi < MAX_TAPS)
        begin : g_used
            assign leaf[gi] = SUM_W'($signed(terms[gi*TERM_W +: TERM_W]));
        end
        else
        begin : g_pad
            assign leaf[gi] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s <= LVL; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // One tree level per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < POW; i++)
            begin
                node_reg[0][i] <= leaf[i];
            end
            meta_reg[0] <= in_meta;
            for (int s = 1; s <= LVL; s++)
            begin
                for (int i = 0; i < POW / 2; i++)
                begin
                    node_reg[s][i] <= node_reg[s-1][2*i] + node_reg[s-1][2*i+1];
                end
                meta_reg[s] <= meta_reg[s-1];
            end
        end
    end

    assign out_valid = vld_reg[LVL];
    assign out_meta  = meta_reg[LVL];
    assign sum       = node_reg[LVL][0];

endmodule

`default_nettype wire

// File: rtl/stm_best.sv
// Best-window tracker and result register with its stream handshake.
// Depends on stm_pkg.
`default_nettype none

module stm_best #(
    parameter int SUM_W  = 23,
    parameter int BAR_W  = 23,
    parameter int BEST_W = 13
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           fin_valid,
    input  wire stm_pkg::meta_t                 fin_meta,
    input  wire logic signed [SUM_W-1:0]        fin_sum,
    input  wire logic signed [BAR_W-1:0]        bar,
    output logic                                stall,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic                                matched,
    output logic [stm_pkg::POS_W-1:0]           position,
    output logic [stm_pkg::SCORE_W-1:0]         best_score
);
    import stm_pkg::*;

    localparam int CMP_W = ((SUM_W > BAR_W) ? SUM_W : BAR_W) + 1;

    logic                  found_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [BEST_W-1:0]     best_reg;
    logic                  out_vld_reg;
    logic                  matched_reg;
    logic [POS_W-1:0]      position_reg;
    logic [SCORE_W-1:0]    score_reg;

    logic                  en;
    logic                  take;
    logic                  emit;
    logic                  found_next;
    logic [POS_W-1:0]      pos_next;
    logic [BEST_W-1:0]     best_next;
    logic [SCORE_W-1:0]    score_next;
    logic signed [CMP_W-1:0] sum_x;
    logic signed [CMP_W-1:0] bar_x;
    logic signed [CMP_W-1:0] best_x;

    // Hold the pipe only when a second result would overrun the result register
    assign stall = fin_valid && fin_meta.last && out_vld_reg && !m_tready;
    assign en    = !stall;
    assign emit  = en && fin_valid && fin_meta.last;

    always_comb
    begin
        sum_x      = CMP_W'(fin_sum);
        bar_x      = CMP_W'(bar);
        best_x     = $signed(CMP_W'(best_reg));
        take       = fin_valid && fin_meta.scored && (sum_x > bar_x) && (sum_x > best_x);
        found_next = found_reg || take;
        pos_next   = take ? fin_meta.start : pos_reg;
        best_next  = take ? BEST_W'(fin_sum) : best_reg;
        if (!found_next)
        begin
            score_next = '0;
        end
        else if (32'(best_next) > SCORE_MAX)
        begin
            score_next = SCORE_W'(SCORE_MAX);
        end
        else
        begin
            score_next = SCORE_W'(best_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg   <= 1'b0;
            pos_reg     <= '0;
            best_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (en && fin_valid)
            begin
                // Drop the per-set state once the closing sample is scored
                if (fin_meta.last)
                begin
                    found_reg <= 1'b0;
                    pos_reg   <= '0;
                    best_reg  <= '0;
                end
                else
                begin
                    found_reg <= found_next;
                    pos_reg   <= pos_next;
                    best_reg  <= best_next;
                end
            end
            if (emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            matched_reg  <= found_next;
            position_reg <= found_next ? pos_next : '0;
            score_reg    <= score_next;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign matched    = matched_reg;
    assign position   = position_reg;
    assign best_score = score_reg;

endmodule

`default_nettype wire

// File: rtl/sliding_template_matcher.sv
// Top level of the sliding-window template matcher.
// Depends on stm_pkg, stm_cell, stm_tree and stm_best.
`default_nettype none

// Usage
//   Slave stream: one request per accepted beat. tuser = 0 writes value into
//   pattern tap tap_index; tuser = 1 delivers one data sample, tlast marks the
//   final sample of a data set. Master stream: one beat per data set, sent
//   after its tlast sample: matched flag, best start position, best sum.
//   Config port: cfg_wen writes cfg_wdata into register cfg_addr
//   (0 = pattern length, 1 = signed Q8.8 threshold); write it only while idle.
// Timing
//   One request per cycle while s_tready is high. A row of MAX_TAPS cells shifts the window and
//   scores every tap in the cycle a sample is accepted; an adder tree of
//   clog2(MAX_TAPS) registered levels sums the taps and the best-window
//   tracker closes the set into the result register that drives the master side.
// Reset
//   Clears the window, sample count and best-window state; pattern length
//   returns to 16 taps (MAX_TAPS if fewer) and threshold to zero. Pattern
//   taps hold no value until written.
// Backpressure
//   The result register holds a result while m_tready is low and the block
//   keeps taking requests; s_tready drops only when a second result reaches
//   the tracker before the first is taken.

module sliding_template_matcher #(
    parameter int MAX_TAPS    = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    // tdata: tap_index[3:0], value[SAMPLE_BITS+3:4], zero padding above
    input  wire logic [((stm_pkg::TAP_IDX_W+SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    // tuser: func (0 = pattern write, 1 = data sample)
    input  wire logic                                     s_tuser,
    input  wire logic                                     s_tlast,
    input  wire logic                                     s_tvalid,
    output logic                                          s_tready,
    // tdata: matched[0], position[16:1], best_score[29:17], zero padding above
    output logic [stm_pkg::OUT_DATA_W-1:0]                m_tdata,
    output logic                                          m_tvalid,
    input  wire logic                                     m_tready,
    input  wire logic                                     cfg_wen,
    input  wire logic [stm_pkg::CFG_ADDR_W-1:0]           cfg_addr,
    input  wire logic [stm_pkg::THR_W-1:0]                cfg_wdata
);
    import stm_pkg::*;

    localparam int NW     = $clog2(MAX_TAPS + 1);
    localparam int IDX_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TERM_W = SAMPLE_BITS + 2;
    localparam int SUM_W  = SAMPLE_BITS + 3 + $clog2(MAX_TAPS + 1);
    localparam int BAR_W  = THR_W + NW + 1;
    localparam int BEST_W = $clog2(ONE_Q88 * MAX_TAPS + 1);
    localparam int N_RESET = (LEN_RESET > MAX_TAPS) ? MAX_TAPS : LEN_RESET;
    localparam int PAD_W  = OUT_DATA_W - 1 - POS_W - SCORE_W;

    // Configuration
    logic [NW-1:0]             n_reg;
    logic signed [THR_W-1:0]   thr_reg;
    logic signed [BAR_W-1:0]   bar_reg;
    logic [NW-1:0]             n_new;
    logic [LEN_W-1:0]          len_in;

    // Input side
    logic                      en;
    logic                      stall;
    logic                      acc;
    logic                      smp;
    logic                      ld;
    logic                      clear;
    logic [TAP_IDX_W-1:0]      tap_index;
    logic [IDX_W-1:0]          tap_idx;
    logic signed [SAMPLE_BITS-1:0] value;

    // Pattern and cell row
    logic signed [SAMPLE_BITS-1:0] pat_reg [0:MAX_TAPS-1];
    logic [MAX_TAPS*SAMPLE_BITS-1:0] rev_flat;
    logic [MAX_TAPS*SAMPLE_BITS-1:0] aligned_flat;
    logic [IDX_W-1:0]          shift_amt;
    logic [MAX_TAPS-1:0]       use_tap;
    logic signed [SAMPLE_BITS-1:0] win [0:MAX_TAPS-1];
    logic [MAX_TAPS*TERM_W-1:0] terms;

    // Sample position
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic [COUNT_W-1:0]        start_full;
    meta_t                     in_meta;

    // Tree to tracker
    logic                      fin_valid;
    meta_t                     fin_meta;
    logic signed [SUM_W-1:0]   fin_sum;
    logic                      matched;
    logic [POS_W-1:0]          position;
    logic [SCORE_W-1:0]        best_score;

    assign tap_index = s_tdata[TAP_IDX_W-1:0];
    assign value     = $signed(s_tdata[TAP_IDX_W +: SAMPLE_BITS]);
    assign tap_idx   = IDX_W'(tap_index);

    assign en       = !stall;
    assign s_tready = en;
    assign acc      = s_tvalid && en;
    assign smp      = acc && (s_tuser == FUNC_DATA);
    assign ld       = acc && (s_tuser == FUNC_LOAD);
    assign clear    = smp && s_tlast;

    // Clamp the requested length into 1..MAX_TAPS
    always_comb
    begin
        len_in = cfg_wdata[LEN_W-1:0];
        if (len_in == '0)
        begin
            n_new = NW'(1);
        end
        else if (32'(len_in) > MAX_TAPS)
        begin
            n_new = NW'(MAX_TAPS);
        end
        else
        begin
            n_new = NW'(len_in);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg   <= NW'(N_RESET);
            thr_reg <= '0;
            bar_reg <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_PATTERN_LENGTH: n_reg   <= n_new;
                    REG_THRESHOLD:      thr_reg <= $signed(cfg_wdata);
                    default:            n_reg   <= n_reg;
                endcase
            end
            // Threshold x tap count; user, not block, lets it settle before any sample arrives
            bar_reg <= BAR_W'(thr_reg) * $signed(BAR_W'(n_reg));
        end
    end

    // Pattern taps, undefined until written
    always_ff @(posedge clk)
    begin
        if (ld && (32'(tap_index) < MAX_TAPS))
        begin
            pat_reg[tap_idx] <= value;
        end
    end

    // Line tap j of the pattern up with window slot n-1-j: reverse, then shift
    // down by MAX_TAPS - n words
    assign shift_amt = IDX_W'(MAX_TAPS - int'(n_reg));

    always_comb
    begin
        for (int m = 0; m < MAX_TAPS; m++)
        begin
            rev_flat[m*SAMPLE_BITS +: SAMPLE_BITS] = pat_reg[MAX_TAPS-1-m];
        end
        aligned_flat = rev_flat;
        for (int b = 0; b < IDX_W; b++)
        begin
            if (shift_amt[b])
            begin
                aligned_flat = aligned_flat >> (SAMPLE_BITS << b);
            end
        end
        for (int k = 0; k < MAX_TAPS; k++)
        begin
            use_tap[k] = NW'(k) < n_reg;
        end
    end

    // Row of cells; the newest sample enters cell 0 and moves up one cell per sample
    for (genvar gk = 0; gk < MAX_TAPS; gk++)
    begin : g_cell
        logic signed [SAMPLE_BITS-1:0] shift_in;
        logic signed [TERM_W-1:0]      term;

        if (gk == 0)
        begin : g_head
            assign shift_in = value;
        end
        else
        begin : g_link
            assign shift_in = win[gk-1];
        end

        stm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_en  (smp),
            .clear     (clear),
            .use_tap   (use_tap[gk]),
            .sample_in (shift_in),
            .pattern   ($signed(aligned_flat[gk*SAMPLE_BITS +: SAMPLE_BITS])),
            .window    (win[gk]),
            .term      (term)
        );

        assign terms[gk*TERM_W +: TERM_W] = term;
    end

    // Saturating sample count and window start position
    always_comb
    begin
        count_next     = (count_reg == COUNT_MAX) ? count_reg : (count_reg + 1'b1);
        start_full     = count_next - COUNT_W'(n_reg);
        in_meta.last   = s_tlast;
        in_meta.scored = count_next >= COUNT_W'(n_reg);
        in_meta.start  = (start_full > COUNT_W'(POS_MAX)) ? POS_W'(POS_MAX)
                                                          : start_full[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (smp)
        begin
            count_reg <= s_tlast ? '0 : count_next;
        end
    end

    stm_tree #(
        .MAX_TAPS (MAX_TAPS),
        .TERM_W   (TERM_W),
        .SUM_W    (SUM_W)
    ) u_tree (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (smp),
        .in_meta   (in_meta),
        .terms     (terms),
        .out_valid (fin_valid),
        .out_meta  (fin_meta),
        .sum       (fin_sum)
    );

    stm_best #(
        .SUM_W  (SUM_W),
        .BAR_W  (BAR_W),
        .BEST_W (BEST_W)
    ) u_best (
        .clk        (clk),
        .rst_n      (rst_n),
        .fin_valid  (fin_valid),
        .fin_meta   (fin_meta),
        .fin_sum    (fin_sum),
        .bar        (bar_reg),
        .stall      (stall),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .matched    (matched),
        .position   (position),
        .best_score (best_score)
    );

    assign m_tdata = {{PAD_W{1'b0}}, best_score, position, matched};

endmodule

`default_nettype wire
